// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by joystick_median_scaler.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/jms_pkg.sv =====
// package with sizes, constants and types of the joystick median scaler
package jms_pkg;

    localparam int WINDOW      = 8;
    localparam int SAMPLE_W    = 12;
    localparam int OUT_W       = 10;
    localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int RANK        = WINDOW / 2;
    localparam int SCALE_W     = 10;
    localparam int SCALE_NUM   = 1000;
    localparam int PROD_W      = SAMPLE_W + SCALE_W;
    localparam int BIT_CNT_W   = $clog2(SAMPLE_W);
    localparam int IN_DATA_W   = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((2 * OUT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELECT,
        ST_SCALE,
        ST_OUT
    } jms_state_t;

    // control from the sequencer to each axis unit
    typedef struct packed {
        logic load;
        logic step;
    } jms_ctrl_t;

endpackage

// ===== hw/rtl/jms_axis.sv =====
// one axis: sample window and bit-serial radix selection of the median
module jms_axis (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  jms_pkg::jms_ctrl_t              ctrl,
    input  logic [jms_pkg::SLOT_W-1:0]      wr_slot,
    input  logic [jms_pkg::SAMPLE_W-1:0]    wr_data,
    output logic [jms_pkg::SAMPLE_W-1:0]    median
);
    import jms_pkg::*;

    logic [SAMPLE_W-1:0] win_reg [WINDOW];
    logic [WINDOW-1:0]   active_reg;
    logic [WINDOW-1:0]   active_next;
    logic [CNT_W-1:0]    rank_reg;
    logic [CNT_W-1:0]    rank_next;
    logic [SAMPLE_W-1:0] med_reg;
    logic [WINDOW-1:0]   msb;
    logic [CNT_W-1:0]    zeros;
    logic                pick_one;

    always_comb begin
        zeros = '0;
        for (int i = 0; i < WINDOW; i++) begin
            msb[i] = win_reg[i][SAMPLE_W-1];
            zeros  = zeros + CNT_W'(active_reg[i] & ~msb[i]);
        end
        // target rank lies beyond the candidates with a zero here
        pick_one = (rank_reg >= zeros);
        if (pick_one) begin
            active_next = active_reg & msb;
            rank_next   = rank_reg - zeros;
        end else begin
            active_next = active_reg & ~msb;
            rank_next   = rank_reg;
        end
    end

    // entries rotate one bit per step and are back in place after a full pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                win_reg[i] <= '0;
            end
        end else if (ctrl.load) begin
            win_reg[wr_slot] <= wr_data;
        end else if (ctrl.step) begin
            for (int i = 0; i < WINDOW; i++) begin
                win_reg[i] <= {win_reg[i][SAMPLE_W-2:0], win_reg[i][SAMPLE_W-1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            rank_reg   <= '0;
        end else if (ctrl.load) begin
            active_reg <= '1;
            rank_reg   <= CNT_W'(RANK);
        end else if (ctrl.step) begin
            active_reg <= active_next;
            rank_reg   <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            med_reg <= {med_reg[SAMPLE_W-2:0], pick_one};
        end
    end

    assign median = med_reg;

endmodule

// ===== hw/rtl/joystick_median_scaler.sv =====
// joystick median scaler: per-axis window median, scaled to 0..999 and 1000..1
//
// input channel s_*: one item carries an x and a y sample; s_tready is high
// while the block is idle, also while a finished result still waits on m_*
// output channel m_*: one item per input item, held in an output register
// until taken; m_tvalid stays high and m_tdata stays put while m_tready is low
//
// each accepted item is written into both windows at the shared write slot,
// then the median of each window is found msb first, one bit per cycle over
// all window entries, then scaled in ST_SCALE into the product registers;
// the result is loaded into the output register in ST_OUT once it is empty
// or being taken; a new item is accepted only after that load, and while
// m_tready is low the next item waits in ST_OUT for the output register
// to empty
// reset: both windows read as all zeros and the write slot returns to the
// first entry, so early medians include those zeros; no item is pending
module joystick_median_scaler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [jms_pkg::IN_DATA_W-1:0]     s_tdata,   // x_sample, y_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [jms_pkg::OUT_DATA_W-1:0]    m_tdata    // x_scaled, y_scaled, zero pad
);
    import jms_pkg::*;

    `include "assert_macros.svh"

    jms_state_t               state_reg, state_next;
    logic [BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]         x_out_reg;
    logic [OUT_W-1:0]         y_out_reg;
    logic [PROD_W-1:0]        x_prod_reg;
    logic [PROD_W-1:0]        y_prod_reg;
    logic [SAMPLE_W-1:0]      x_med;
    logic [SAMPLE_W-1:0]      y_med;
    logic [OUT_W-1:0]         x_q;
    logic [OUT_W-1:0]         y_q;
    logic                     accept;
    logic                     out_load;
    jms_ctrl_t                ctrl;

    assign accept = s_tvalid && s_tready;

    jms_axis u_axis_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .wr_slot (slot_reg),
        .wr_data (s_tdata[SAMPLE_W-1:0]),
        .median  (x_med)
    );

    jms_axis u_axis_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .wr_slot (slot_reg),
        .wr_data (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .median  (y_med)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= '0;
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            slot_reg     <= slot_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        slot_next     = slot_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        out_load      = 1'b0;
        ctrl          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
                if (s_tvalid) begin
                    bit_cnt_next = '0;
                    if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                        slot_next = '0;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT: begin
                ctrl.step    = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(SAMPLE_W - 1)) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to empty
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCALE) begin
            x_prod_reg <= PROD_W'(x_med) * PROD_W'(SCALE_NUM);
            y_prod_reg <= PROD_W'(y_med) * PROD_W'(SCALE_NUM);
        end
    end

    assign x_q = x_prod_reg[PROD_W-1:SAMPLE_W];
    assign y_q = y_prod_reg[PROD_W-1:SAMPLE_W];

    always_ff @(posedge aclk) begin
        if (out_load) begin
            x_out_reg <= x_q;
            y_out_reg <= OUT_W'(SCALE_NUM) - y_q;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2 * OUT_W){1'b0}}, y_out_reg, x_out_reg};

    `ASSERT_NEXT(a_accept_starts_select, accept, state_reg == ST_SELECT)
    `ASSERT_NEXT(a_select_ends_in_scale,
        state_reg == ST_SELECT && bit_cnt_reg == BIT_CNT_W'(SAMPLE_W - 1),
        state_reg == ST_SCALE)
    `ASSERT_NOW(a_x_range, m_tvalid_reg, x_out_reg <= OUT_W'(SCALE_NUM - 1))
    `ASSERT_NOW(a_y_range, m_tvalid_reg,
        y_out_reg >= OUT_W'(1) && y_out_reg <= OUT_W'(SCALE_NUM))

endmodule
